// ----- rtl/core/rfad_pkg.sv -----
// rfad_pkg: constants, types and the hex character decode for the tag-reader frame decoder
// no dependencies; used by rfad_decode and rfid_ascii_frame_decoder_unit
`default_nettype none

package rfad_pkg;

	// frame geometry
	localparam int CHAR_PAIRS = 6;
	localparam int WIN_LEN    = 2 * CHAR_PAIRS + 3;
	localparam int ID_CHARS   = 2 * (CHAR_PAIRS - 1);
	localparam int ID_FULL_W  = 4 * ID_CHARS;
	localparam int CARD_ID_W  = 40;
	localparam int BYTE_W     = 8;

	// frame marker bytes
	localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
	localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;

	// ascii hex character bounds
	localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_F = 8'h46;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef byte_t [WIN_LEN-1:0] window_t;

	// decode result handed from the decoder to the output stage
	typedef struct packed {
		logic                 done;
		logic                 fresh;
		logic [CARD_ID_W-1:0] id;
	} rfad_result_t;

	// one ascii hex character to its value, anything else is zero
	function automatic logic [3:0] hex_nibble(input byte_t c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			n = 4'(c - CHAR_0);
		end else if (c >= CHAR_A && c <= CHAR_F) begin
			n = 4'(c - CHAR_A + 8'd10);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rfad_decode.sv -----
// rfad_decode: frame match, card id decode and new-card compare for one byte
// depends on rfad_pkg
`default_nettype none

module rfad_decode (
	input  wire rfad_pkg::window_t      window,
	input  wire rfad_pkg::byte_t        cur_byte,
	input  wire [rfad_pkg::CARD_ID_W-1:0] last_id,
	output rfad_pkg::rfad_result_t      result
);

	logic [rfad_pkg::ID_FULL_W-1:0] id_full;
	logic [rfad_pkg::CARD_ID_W-1:0] id;
	logic                           done;

	// frame markers: oldest byte is stx, then cr, lf and the current etx
	assign done = (window[0] == rfad_pkg::BYTE_STX) &&
		(window[rfad_pkg::WIN_LEN-2] == rfad_pkg::BYTE_CR) &&
		(window[rfad_pkg::WIN_LEN-1] == rfad_pkg::BYTE_LF) &&
		(cur_byte == rfad_pkg::BYTE_ETX);

	// hex decode of the id characters, first character most significant
	always_comb begin
		id_full = '0;
		for (int k = 0; k < rfad_pkg::ID_CHARS; k++) begin
			id_full[(rfad_pkg::ID_CHARS-1-k)*4 +: 4] = rfad_pkg::hex_nibble(window[1+k]);
		end
		id = rfad_pkg::CARD_ID_W'(id_full);
	end

	// pack result, the checksum characters are ignored
	always_comb begin
		result.done  = done;
		result.fresh = done && (id != last_id);
		result.id    = done ? id : last_id;
	end

endmodule

`default_nettype wire

// ----- rtl/core/rfid_ascii_frame_decoder_unit.sv -----
// rfid_ascii_frame_decoder_unit: top level of the tag-reader ascii frame decoder
// depends on rfad_pkg and rfad_decode
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   in      | in_valid, in_stall | rx_byte
//   out     | out_valid, out_stall | frame_done, new_card, card_id
//
// one request per cycle sustained while out_stall stays low; each byte passes
// through the input register, then through the decoder into the result register
// reset clears the byte window, the last card id and both valid flags
// out_stall holds the result register; the input register still takes a byte
// while the result waits, and in_stall rises only when both are full
`default_nettype none

module rfid_ascii_frame_decoder_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire [rfad_pkg::BYTE_W-1:0]     rx_byte,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic                           frame_done,
	output logic                           new_card,
	output logic [rfad_pkg::CARD_ID_W-1:0] card_id
);

	logic                           valid_s1;
	rfad_pkg::byte_t                byte_s1;
	rfad_pkg::window_t              window_q;
	logic [rfad_pkg::CARD_ID_W-1:0] last_card_id_q;
	logic                           out_valid_q;
	logic                           frame_done_q;
	logic                           new_card_q;
	logic [rfad_pkg::CARD_ID_W-1:0] card_id_q;
	rfad_pkg::rfad_result_t         result;
	logic                           advance;
	logic                           in_take;

	// handshake control
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame decode against the window of earlier bytes
	rfad_decode u_decode (
		.window   (window_q),
		.cur_byte (byte_s1),
		.last_id  (last_card_id_q),
		.result   (result)
	);

	// byte window and last id advance with each byte that leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q       <= '0;
			last_card_id_q <= '0;
		end else if (valid_s1 && advance) begin
			for (int i = 0; i < rfad_pkg::WIN_LEN - 1; i++) begin
				window_q[i] <= window_q[i+1];
			end
			window_q[rfad_pkg::WIN_LEN-1] <= byte_s1;
			last_card_id_q                <= result.id;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			frame_done_q <= result.done;
			new_card_q   <= result.fresh;
			card_id_q    <= result.id;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_done = frame_done_q;
	assign new_card   = new_card_q;
	assign card_id    = card_id_q;

`ifndef SYNTHESIS
	// a new card is only ever flagged on a completed frame
	a_new_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!new_card_q || frame_done_q))
		else $error("new_card without frame_done");

	// the shown id always matches the remembered id
	a_id_tracks_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (card_id_q == last_card_id_q))
		else $error("card_id differs from last card id");

	// input is stalled only while stage one holds a byte
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall with empty stage one");

	// a blocked stage-one byte is kept
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stage one byte lost while blocked");
`endif

endmodule

`default_nettype wire
